// ----- design/dprc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dprc_pkg;

    localparam int LEVEL_W = 16;
    localparam int STEP_W  = 8;
    localparam int PULSE_W = 8;
    localparam int PHASE_W = 4;
    localparam int OUT_CH  = 4;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_GOAL = 2'd1;
    localparam logic [1:0] CMD_SET_STEP = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  channel;
        logic [11:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] pulse_ch0;
        logic [7:0] pulse_ch1;
        logic [7:0] pulse_ch2;
        logic [7:0] pulse_ch3;
        logic       enable_ch0;
        logic       enable_ch1;
        logic       enable_ch2;
        logic       enable_ch3;
        logic [3:0] phase_now;
    } out_beat_t;

    typedef struct packed {
        logic wr_goal;
        logic wr_step;
        logic ramp;
    } chan_ctl_t;

    localparam logic [15:0] DITHER_TABLE [16] = '{
        16'h0000, 16'h8000, 16'h8080, 16'h8880,
        16'h8888, 16'h9888, 16'h9898, 16'h9899,
        16'h9999, 16'hD999, 16'hD9D9, 16'hDDD9,
        16'hDDDD, 16'hFDDD, 16'hFDFD, 16'hFFFD
    };

    // top byte plus dither bit, saturated
    function automatic logic [PULSE_W-1:0] pulse_len(
        input logic [LEVEL_W-1:0] lvl,
        input logic [PHASE_W-1:0] ph
    );
        logic [15:0]        pat;
        logic [PULSE_W:0]   sum;
        pat = DITHER_TABLE[lvl[7:4]];
        sum = {1'b0, lvl[15:8]} + {{PULSE_W{1'b0}}, pat[ph]};
        if (sum[PULSE_W]) begin
            pulse_len = {PULSE_W{1'b1}};
        end else begin
            pulse_len = sum[PULSE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- design/dprc_chan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dprc_chan (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire dprc_pkg::chan_ctl_t     ctl,
    input  wire logic [11:0]             value,
    output logic [dprc_pkg::LEVEL_W-1:0] level_next
);
    import dprc_pkg::*;

    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] goal_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W-1:0] step_ext;
    logic [LEVEL_W-1:0] ramped;

    assign step_ext = {{(LEVEL_W-STEP_W){1'b0}}, step_reg};

    always_comb begin
        if (level_reg > goal_reg) begin
            diff   = level_reg - goal_reg;
            ramped = (diff < step_ext) ? goal_reg : level_reg - step_ext;
        end else begin
            diff   = goal_reg - level_reg;
            ramped = (diff < step_ext) ? goal_reg : level_reg + step_ext;
        end
        level_next = ctl.ramp ? ramped : level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            goal_reg  <= '0;
            step_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (ctl.wr_goal) begin
                goal_reg <= {value, 4'b0000};
            end
            if (ctl.wr_step) begin
                step_reg <= value[STEP_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/dithered_pwm_ramp_controller_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Dithered PWM engine with per-channel slew-rate ramp.
// Input channel s_*: one command beat per cycle while s_ready is high.
// A tick advances the 4-bit dither phase; when the phase wraps to 0 every
// channel level steps toward its target. Set-target stores value<<4 as
// the target, set-step keeps value[7:0] as the ramp step. Set commands for
// channels >= NUM_CHANNELS and the unused code are dropped without a result.
// Result channel m_*: one beat per tick carrying four saturated pulse
// lengths, four enable flags and the phase used.
// Latency: a tick's result is valid the cycle after the tick is accepted.
// Throughput: one beat per cycle while m_ready is high; ramp, table lookup
// and add sit in a single stage between the command and the result register.
// Stall: a full result register holds while m_ready is low; s_ready drops
// only when that register is full and not being drained.
// Reset (aresetn low, synchronous): levels, targets, steps and phase clear
// to zero and the result register empties.
module dithered_pwm_ramp_controller_unit #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dprc_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dprc_pkg::out_beat_t      m_data
);
    import dprc_pkg::*;

    logic                s_acc;
    logic                is_tick;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic                m_valid_reg;
    out_beat_t           m_data_reg;
    out_beat_t           m_data_next;
    logic [LEVEL_W-1:0]  level_next [NUM_CHANNELS];
    logic [LEVEL_W-1:0]  level_out  [OUT_CH];
    logic [PULSE_W-1:0]  pulse      [OUT_CH];
    logic [OUT_CH-1:0]   enable;

    assign s_ready    = !m_valid_reg || m_ready;
    assign s_acc      = s_valid && s_ready;
    assign is_tick    = s_acc && (s_data.cmd == CMD_TICK);
    assign phase_next = phase_reg + PHASE_W'(1);

    for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
        chan_ctl_t ctl;
        assign ctl.wr_goal = s_acc && (s_data.cmd == CMD_SET_GOAL)
                             && (s_data.channel == 4'(i));
        assign ctl.wr_step = s_acc && (s_data.cmd == CMD_SET_STEP)
                             && (s_data.channel == 4'(i));
        assign ctl.ramp    = is_tick && (phase_next == '0);

        dprc_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .value      (s_data.value),
            .level_next (level_next[i])
        );
    end

    for (genvar j = 0; j < OUT_CH; j++) begin : g_out
        if (j < NUM_CHANNELS) begin : g_hw
            assign level_out[j] = level_next[j];
        end else begin : g_none
            assign level_out[j] = '0;
        end
        assign pulse[j]  = pulse_len(level_out[j], phase_next);
        assign enable[j] = (level_out[j] != '0);
    end

    always_comb begin
        m_data_next.pulse_ch0  = pulse[0];
        m_data_next.pulse_ch1  = pulse[1];
        m_data_next.pulse_ch2  = pulse[2];
        m_data_next.pulse_ch3  = pulse[3];
        m_data_next.enable_ch0 = enable[0];
        m_data_next.enable_ch1 = enable[1];
        m_data_next.enable_ch2 = enable[2];
        m_data_next.enable_ch3 = enable[3];
        m_data_next.phase_now  = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (is_tick) begin
                phase_reg   <= phase_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_tick) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_tick_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        is_tick |=> m_valid)
        else $error("tick accepted without result beat");

    a_cmd_keeps_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.cmd != CMD_TICK) |=> (!m_valid || $stable(m_data)))
        else $error("non-tick command disturbed result");

    a_phase_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.phase_now == phase_reg))
        else $error("result phase differs from phase counter");

    a_pulse_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.pulse_ch0 != 8'd0) |-> m_data.enable_ch0)
        else $error("pulse on channel 0 with enable low");
`endif

endmodule

`default_nettype wire

// ----- bench/dithered_pwm_ramp_controller_unit_tb.sv -----
`timescale 1ns / 1ps

module dithered_pwm_ramp_controller_unit_tb;

    import dprc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         RANDOM_CMDS = 420;
    localparam int         CALM_TAIL   = 80;

    class pwm_frame_board;
        logic [15:0] lvl_cur   [OUT_CH];
        logic [15:0] lvl_tgt   [OUT_CH];
        logic [7:0]  ramp_step [OUT_CH];
        logic [15:0] spread    [16];
        logic [3:0]  dither_phase;
        out_beat_t   frames_due [$];
        int          mismatches;
        int          frames_seen;
        int          cmds_taken;
        int          ticks_taken;

        function new();
            spread = '{16'h0000, 16'h8000, 16'h8080, 16'h8880,
                       16'h8888, 16'h9888, 16'h9898, 16'h9899,
                       16'h9999, 16'hD999, 16'hD9D9, 16'hDDD9,
                       16'hDDDD, 16'hFDDD, 16'hFDFD, 16'hFFFD};
            foreach (lvl_cur[i]) begin
                lvl_cur[i]   = '0;
                lvl_tgt[i]   = '0;
                ramp_step[i] = '0;
            end
            dither_phase = '0;
            mismatches   = 0;
            frames_seen  = 0;
            cmds_taken   = 0;
            ticks_taken  = 0;
        endfunction

        // move one channel toward its target, clamped at the target
        function void slew(int ch);
            int unsigned cur;
            int unsigned tgt;
            int unsigned st;
            cur = lvl_cur[ch];
            tgt = lvl_tgt[ch];
            st  = ramp_step[ch];
            if (cur > tgt) begin
                cur = (cur - tgt < st) ? tgt : cur - st;
            end else begin
                cur = (tgt - cur < st) ? tgt : cur + st;
            end
            lvl_cur[ch] = 16'(cur);
        endfunction

        function logic [7:0] pulse_of(int ch);
            logic [15:0] lv;
            logic        dbit;
            lv   = lvl_cur[ch];
            dbit = spread[lv[7:4]][dither_phase];
            if (lv[15:8] == 8'hFF) begin
                return 8'hFF;
            end
            return lv[15:8] + 8'(dbit);
        endfunction

        function void note_command(in_beat_t b);
            out_beat_t f;
            cmds_taken++;
            case (b.cmd)
                CMD_SET_GOAL: begin
                    if (b.channel < OUT_CH) lvl_tgt[b.channel] = {b.value, 4'h0};
                end
                CMD_SET_STEP: begin
                    if (b.channel < OUT_CH) ramp_step[b.channel] = b.value[7:0];
                end
                CMD_TICK: begin
                    ticks_taken++;
                    dither_phase = dither_phase + 4'd1;
                    if (dither_phase == 4'd0) begin
                        for (int i = 0; i < OUT_CH; i++) slew(i);
                    end
                    f.pulse_ch0  = pulse_of(0);
                    f.pulse_ch1  = pulse_of(1);
                    f.pulse_ch2  = pulse_of(2);
                    f.pulse_ch3  = pulse_of(3);
                    f.enable_ch0 = (lvl_cur[0] != '0);
                    f.enable_ch1 = (lvl_cur[1] != '0);
                    f.enable_ch2 = (lvl_cur[2] != '0);
                    f.enable_ch3 = (lvl_cur[3] != '0);
                    f.phase_now  = dither_phase;
                    frames_due.push_back(f);
                end
                default: ;
            endcase
        endfunction

        function void match(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", fname, want, got);
                mismatches++;
            end
        endfunction

        function void check_frame(out_beat_t got);
            out_beat_t want;
            frames_seen++;
            if (frames_due.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                mismatches++;
                return;
            end
            want = frames_due.pop_front();
            match("pulse_ch0", want.pulse_ch0, got.pulse_ch0);
            match("pulse_ch1", want.pulse_ch1, got.pulse_ch1);
            match("pulse_ch2", want.pulse_ch2, got.pulse_ch2);
            match("pulse_ch3", want.pulse_ch3, got.pulse_ch3);
            match("enable_ch0", want.enable_ch0, got.enable_ch0);
            match("enable_ch1", want.enable_ch1, got.enable_ch1);
            match("enable_ch2", want.enable_ch2, got.enable_ch2);
            match("enable_ch3", want.enable_ch3, got.enable_ch3);
            match("phase_now", want.phase_now, got.phase_now);
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    pwm_frame_board board;
    bit             idle_on     = 1'b1;
    int             stall_left  = 0;
    int             quiet_count = 0;

    dithered_pwm_ramp_controller_unit #(
        .NUM_CHANNELS(OUT_CH)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #6 aclk = ~aclk;

    // result-side backpressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 14);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_frame(m_data);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
        end
        if (quiet_count >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_beat_t cmd_beat(logic [1:0] c, logic [3:0] ch, logic [11:0] v);
        in_beat_t b;
        b.cmd     = c;
        b.channel = ch;
        b.value   = v;
        return b;
    endfunction

    function automatic in_beat_t random_cmd();
        in_beat_t b;
        int       r;
        r = $urandom_range(0, 99);
        if (r < 62) begin
            b.cmd = CMD_TICK;
        end else if (r < 78) begin
            b.cmd = CMD_SET_GOAL;
        end else if (r < 94) begin
            b.cmd = CMD_SET_STEP;
        end else begin
            b.cmd = CMD_UNUSED;
        end
        if ($urandom_range(0, 9) == 0) begin
            b.channel = 4'($urandom_range(OUT_CH, 15));
        end else begin
            b.channel = 4'($urandom_range(0, OUT_CH - 1));
        end
        b.value = 12'($urandom);
        return b;
    endfunction

    function automatic bit is_dropped(in_beat_t b);
        return (b.cmd == CMD_UNUSED) || (b.cmd != CMD_TICK && b.channel >= OUT_CH);
    endfunction

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic push_command(in_beat_t b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(b);
    endtask

    initial begin
        in_beat_t b;
        int       counted;
        board = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ignored commands, payload extremes, zero step on ch0
        push_command(cmd_beat(CMD_UNUSED, 4'd0, 12'hFFF));
        push_command(cmd_beat(CMD_SET_GOAL, 4'd15, 12'hFFF));
        push_command(cmd_beat(CMD_SET_STEP, 4'd4, 12'h0FF));
        push_command(cmd_beat(CMD_SET_GOAL, 4'd0, 12'hFFF));
        push_command(cmd_beat(CMD_SET_GOAL, 4'd1, 12'h800));
        push_command(cmd_beat(CMD_SET_STEP, 4'd1, 12'hFFF));
        push_command(cmd_beat(CMD_SET_GOAL, 4'd2, 12'h001));
        push_command(cmd_beat(CMD_SET_STEP, 4'd2, 12'h001));
        push_command(cmd_beat(CMD_SET_GOAL, 4'd3, 12'h0FF));
        push_command(cmd_beat(CMD_SET_STEP, 4'd3, 12'hF10));
        repeat (16) push_command(cmd_beat(CMD_TICK, 4'($urandom), 12'($urandom)));

        // ramp all channels toward full scale at the largest step
        for (int i = 0; i < OUT_CH; i++) begin
            push_command(cmd_beat(CMD_SET_GOAL, 4'(i), 12'hFFF));
            push_command(cmd_beat(CMD_SET_STEP, 4'(i), 12'h0FF));
        end
        repeat (64) push_command(cmd_beat(CMD_TICK, 4'($urandom), 12'($urandom)));

        counted = 0;
        while (counted < RANDOM_CMDS) begin
            if (counted >= RANDOM_CMDS - CALM_TAIL) begin
                idle_on = 1'b0;
            end else if (counted % 40 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            b = random_cmd();
            push_command(b);
            if (!is_dropped(b)) counted++;
        end
        s_valid <= 1'b0;

        while (board.frames_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d command beats sent, %0d ticks, %0d result beats checked",
                 board.cmds_taken, board.ticks_taken, board.frames_seen);
        $display("ramps toward full scale, ignored channels and codes, %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dprc_pkg.sv
design/dprc_chan.sv
design/dithered_pwm_ramp_controller_unit.sv
bench/dithered_pwm_ramp_controller_unit_tb.sv
